// ===== rtl/sacl_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, register codes and store word types for the cache LRU tracker.
// No dependencies; every other file refers to it by scoped names.
package sacl_pkg;

  localparam int ADDR_W     = 48;
  localparam int LINE_W     = 48;
  localparam int STAMP_W    = 32;
  localparam int TOTAL_W    = 48;
  localparam int SET_OUT_W  = 6;
  localparam int WAY_OUT_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam int SETS_DEF      = 64;
  localparam int WAYS_DEF      = 8;
  localparam int ADDR_BITS_DEF = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_SHIFT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd2;

  localparam logic [3:0] LINE_SHIFT_RST = 4'd6;
  localparam logic [2:0] SET_BITS_RST   = 3'd6;
  localparam logic [3:0] WAYS_USED_RST  = 4'd8;
  localparam logic [3:0] LINE_SHIFT_MAX = 4'd12;
  localparam logic [2:0] SET_BITS_MAX   = 3'd6;

  typedef struct packed {
    logic               line_we;
    logic               acc_we;
    logic               fill_we;
    logic               acc_cnt_we;
    logic               fill_cnt_we;
    logic [LINE_W-1:0]  line;
    logic [STAMP_W-1:0] acc_stamp;
    logic [STAMP_W-1:0] fill_stamp;
    logic [STAMP_W-1:0] acc_cnt;
    logic [STAMP_W-1:0] fill_cnt;
  } store_wr_t;

  typedef struct packed {
    logic [LINE_W-1:0]  line;
    logic [STAMP_W-1:0] acc_stamp;
    logic [STAMP_W-1:0] fill_stamp;
    logic [STAMP_W-1:0] acc_cnt;
    logic [STAMP_W-1:0] fill_cnt;
  } store_rd_t;

endpackage

// ===== rtl/sacl_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the address words in and the result words out.
// Depends on sacl_pkg for field widths.
interface sacl_in_if;
  logic                        valid;
  logic                        ready;
  logic [sacl_pkg::ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface sacl_out_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [sacl_pkg::SET_OUT_W-1:0] set_index;
  logic [sacl_pkg::WAY_OUT_W-1:0] way;
  logic                           evicted;
  logic [sacl_pkg::LINE_W-1:0]    evicted_line;
  logic [sacl_pkg::STAMP_W-1:0]   reuse_distance;
  logic [sacl_pkg::TOTAL_W-1:0]   hit_total;
  logic [sacl_pkg::TOTAL_W-1:0]   miss_total;

  modport source (output valid, output hit, output set_index, output way, output evicted,
                  output evicted_line, output reuse_distance, output hit_total,
                  output miss_total, input ready);
  modport sink   (input valid, input hit, input set_index, input way, input evicted,
                  input evicted_line, input reuse_distance, input hit_total,
                  input miss_total, output ready);
endinterface

// ===== rtl/sacl_store.sv =====
`timescale 1ns / 1ps
// Per-way line and stamp memories, per-set valid flags and access and fill counters.
// One write port, one registered read port each. Depends on sacl_pkg.
module sacl_store #(
  parameter int SETS  = sacl_pkg::SETS_DEF,
  parameter int WAYS  = sacl_pkg::WAYS_DEF,
  parameter int IDX_W = 9,
  parameter int SEL_W = 6
) (
  input  logic                  clk,
  input  logic [IDX_W-1:0]      rd_idx,
  input  logic [IDX_W-1:0]      wr_idx,
  input  logic [SEL_W-1:0]      set_idx,
  input  sacl_pkg::store_wr_t   wr,
  input  logic                  valid_we,
  input  logic [WAYS-1:0]       valid_wdata,
  output sacl_pkg::store_rd_t   rd,
  output logic [WAYS-1:0]       valid_rdata
);

  localparam int DEPTH = SETS * WAYS;

  logic [sacl_pkg::LINE_W-1:0]  line_mem     [DEPTH];
  logic [sacl_pkg::STAMP_W-1:0] acc_mem      [DEPTH];
  logic [sacl_pkg::STAMP_W-1:0] fill_mem     [DEPTH];
  logic [sacl_pkg::STAMP_W-1:0] acc_cnt_mem  [SETS];
  logic [sacl_pkg::STAMP_W-1:0] fill_cnt_mem [SETS];
  logic [WAYS-1:0]              valid_mem    [SETS];

  always_ff @(posedge clk) begin
    if (wr.line_we) begin
      line_mem[wr_idx] <= wr.line;
    end
    if (wr.acc_we) begin
      acc_mem[wr_idx] <= wr.acc_stamp;
    end
    if (wr.fill_we) begin
      fill_mem[wr_idx] <= wr.fill_stamp;
    end
    if (wr.acc_cnt_we) begin
      acc_cnt_mem[set_idx] <= wr.acc_cnt;
    end
    if (wr.fill_cnt_we) begin
      fill_cnt_mem[set_idx] <= wr.fill_cnt;
    end
    if (valid_we) begin
      valid_mem[set_idx] <= valid_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd.line       <= line_mem[rd_idx];
    rd.acc_stamp  <= acc_mem[rd_idx];
    rd.fill_stamp <= fill_mem[rd_idx];
    rd.acc_cnt    <= acc_cnt_mem[set_idx];
    rd.fill_cnt   <= fill_cnt_mem[set_idx];
    valid_rdata   <= valid_mem[set_idx];
  end

endmodule

// ===== rtl/set_assoc_cache_lru_tracker.sv =====
`timescale 1ns / 1ps
// Set-associative cache tracker with least-recently-used replacement.
// Top level: sequencer, totals and result register; uses sacl_pkg,
// sacl_ifs and sacl_store.
//
// Usage:
//   req carries one byte address per word; rsp returns one result word per address
//   (hit, set, way, eviction, reuse distance, running totals). cfg_we/cfg_index/
//   cfg_data write line_shift, set_bits and ways_used; the user must write them only
//   while the block is idle, and the block itself does not enforce it.
//   Each address is handled by one compare unit that walks the ways of its set, one
//   way per cycle through the registered read port of the way memories.
//   After acceptance, SETS is subtracted from the selected set until it lies below
//   SETS; then the ways are walked and the write-back loads the result register.
//   A new address is taken only after the previous one has been written back;
//   req.ready is high only when the sequencer is idle. The result sits in an output
//   register: a new address is accepted while it waits, and the write-back of that
//   address holds until the register is free. Reset sets the totals and registers at
//   once, then a clearing pass (one set per cycle) zeroes the valid flags and per-set
//   counters; req.ready stays low until it ends.
module set_assoc_cache_lru_tracker #(
  parameter int SETS      = sacl_pkg::SETS_DEF,
  parameter int WAYS      = sacl_pkg::WAYS_DEF,
  parameter int ADDR_BITS = sacl_pkg::ADDR_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_data,
  sacl_in_if.sink                           req,
  sacl_out_if.source                        rsp
);

  localparam int AW      = sacl_pkg::ADDR_W;
  localparam int SW      = sacl_pkg::STAMP_W;
  localparam int TW      = sacl_pkg::TOTAL_W;
  localparam int SEL_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WIDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WCNT_W  = $clog2(WAYS + 1);
  localparam int IDX_W   = (SETS * WAYS > 1) ? $clog2(SETS * WAYS) : 1;
  localparam logic [AW-1:0] ADDR_MASK =
    (ADDR_BITS >= AW) ? {AW{1'b1}} : ((AW'(1) << ADDR_BITS) - AW'(1));

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REDUCE = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_CLEAR  = 5'b10000
  } state_t;

  state_t state;

  logic [3:0] line_shift;
  logic [2:0] set_bits;
  logic [3:0] ways_used;

  logic [sacl_pkg::LINE_W-1:0] line;
  logic [5:0]                  red;
  logic [SEL_W-1:0]            sel;
  logic [SEL_W-1:0]            clr_idx;
  logic [WCNT_W-1:0]           nways;
  logic [WCNT_W-1:0]           cnt;
  logic                        found;
  logic [WIDX_W-1:0]           f_way;
  logic [SW-1:0]               fstamp;
  logic                        have_empty;
  logic [WIDX_W-1:0]           e_way;
  logic [WIDX_W-1:0]           v_way;
  logic [SW-1:0]               min_stamp;
  logic [sacl_pkg::LINE_W-1:0] ev_line;
  logic [TW-1:0]               hits;
  logic [TW-1:0]               misses;

  logic                        o_valid;
  logic                        o_hit;
  logic [5:0]                  o_set;
  logic [2:0]                  o_way;
  logic                        o_ev;
  logic [sacl_pkg::LINE_W-1:0] o_evline;
  logic [SW-1:0]               o_reuse;

  logic [AW-1:0]               addr_m;
  logic [3:0]                  shift_c;
  logic [2:0]                  sb_c;
  logic [5:0]                  sb_mask;
  logic [4:0]                  nw_wide;
  logic [WCNT_W-1:0]           nw_c;
  logic [WIDX_W-1:0]           p_way;
  logic [WIDX_W-1:0]           scan_way;
  logic                        p_valid;
  logic [SW-1:0]               acc_c;
  logic [SW-1:0]               fill_c;
  logic [WIDX_W-1:0]           way_sel;
  logic                        go;
  logic [IDX_W-1:0]            rd_idx;
  logic [IDX_W-1:0]            wr_idx;
  logic [SEL_W-1:0]            set_addr;
  logic                        valid_we;
  logic [WAYS-1:0]             valid_wdata;
  logic [WAYS-1:0]             rd_valid;
  sacl_pkg::store_wr_t         wr;
  sacl_pkg::store_rd_t         rd;

  assign addr_m   = req.address & ADDR_MASK;
  assign shift_c  = (line_shift > sacl_pkg::LINE_SHIFT_MAX) ? sacl_pkg::LINE_SHIFT_MAX
                                                            : line_shift;
  assign sb_c     = (set_bits > sacl_pkg::SET_BITS_MAX) ? sacl_pkg::SET_BITS_MAX : set_bits;
  assign sb_mask  = 6'((7'd1 << sb_c) - 7'd1);
  assign nw_wide  = (ways_used == 4'd0) ? 5'd1 :
                    (({1'b0, ways_used} > 5'(WAYS)) ? 5'(WAYS) : {1'b0, ways_used});
  assign nw_c     = WCNT_W'(nw_wide);

  assign scan_way = cnt[WIDX_W-1:0];
  assign p_way    = WIDX_W'(cnt - WCNT_W'(1));
  assign p_valid  = rd_valid[p_way];
  assign acc_c    = rd.acc_cnt;
  assign fill_c   = rd.fill_cnt;
  assign way_sel  = found ? f_way : (have_empty ? e_way : v_way);
  assign go       = (state == ST_UPDATE) && (!o_valid || rsp.ready);
  assign set_addr = (state == ST_CLEAR) ? clr_idx : sel;

  assign rd_idx = IDX_W'(32'(sel) * WAYS + 32'(scan_way));
  assign wr_idx = IDX_W'(32'(sel) * WAYS + 32'(way_sel));

  always_comb begin
    wr             = '0;
    wr.line        = line;
    wr.acc_stamp   = acc_c;
    wr.fill_stamp  = fill_c;
    wr.acc_cnt     = acc_c + SW'(1);
    wr.fill_cnt    = fill_c + SW'(1);
    valid_we       = 1'b0;
    valid_wdata    = rd_valid | (WAYS'(1) << way_sel);
    if (state == ST_CLEAR) begin
      wr.acc_cnt     = '0;
      wr.fill_cnt    = '0;
      wr.acc_cnt_we  = 1'b1;
      wr.fill_cnt_we = 1'b1;
      valid_we       = 1'b1;
      valid_wdata    = '0;
    end else if (go) begin
      wr.acc_we      = 1'b1;
      wr.acc_cnt_we  = 1'b1;
      wr.line_we     = !found;
      wr.fill_we     = !found;
      wr.fill_cnt_we = !found;
      valid_we       = 1'b1;
    end
  end

  sacl_store #(
    .SETS  (SETS),
    .WAYS  (WAYS),
    .IDX_W (IDX_W),
    .SEL_W (SEL_W)
  ) u_store (
    .clk         (clk),
    .rd_idx      (rd_idx),
    .wr_idx      (wr_idx),
    .set_idx     (set_addr),
    .wr          (wr),
    .valid_we    (valid_we),
    .valid_wdata (valid_wdata),
    .rd          (rd),
    .valid_rdata (rd_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      line_shift <= sacl_pkg::LINE_SHIFT_RST;
      set_bits   <= sacl_pkg::SET_BITS_RST;
      ways_used  <= sacl_pkg::WAYS_USED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sacl_pkg::CFG_LINE_SHIFT: line_shift <= cfg_data[3:0];
        sacl_pkg::CFG_SET_BITS:   set_bits   <= cfg_data[2:0];
        sacl_pkg::CFG_WAYS_USED:  ways_used  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      o_valid <= 1'b0;
      hits    <= '0;
      misses  <= '0;
      cnt     <= '0;
    end else begin
      if (o_valid && rsp.ready && !go) begin
        o_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (clr_idx == SEL_W'(SETS - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_idx <= clr_idx + SEL_W'(1);
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            line       <= addr_m >> shift_c;
            red        <= 6'(addr_m >> shift_c) & sb_mask;
            nways      <= nw_c;
            cnt        <= '0;
            found      <= 1'b0;
            have_empty <= 1'b0;
            state      <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (32'(red) >= SETS) begin
            red <= red - 6'(SETS);
          end else begin
            sel   <= SEL_W'(red);
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt != '0) begin
            if (p_valid) begin
              if (!found && rd.line == line) begin
                found  <= 1'b1;
                f_way  <= p_way;
                fstamp <= rd.fill_stamp;
              end
            end else if (!have_empty) begin
              have_empty <= 1'b1;
              e_way      <= p_way;
            end
            if (p_way == '0 || (p_valid && rd.acc_stamp < min_stamp)) begin
              min_stamp <= rd.acc_stamp;
              v_way     <= p_way;
              ev_line   <= rd.line;
            end
          end
          if (cnt == nways) begin
            state <= ST_UPDATE;
          end else begin
            cnt <= cnt + WCNT_W'(1);
          end
        end
        ST_UPDATE: begin
          if (go) begin
            o_valid  <= 1'b1;
            o_hit    <= found;
            o_set    <= 6'(sel);
            o_way    <= 3'(way_sel);
            o_ev     <= !found && !have_empty;
            o_evline <= (!found && !have_empty) ? ev_line : '0;
            o_reuse  <= found ? (fill_c - fstamp - SW'(1)) : '0;
            if (found) begin
              hits <= hits + TW'(1);
            end else begin
              misses <= misses + TW'(1);
            end
            if (found) begin
              rsp.hit_total  <= hits + TW'(1);
              rsp.miss_total <= misses;
            end else begin
              rsp.hit_total  <= hits;
              rsp.miss_total <= misses + TW'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign req.ready          = (state == ST_IDLE);
  assign rsp.valid          = o_valid;
  assign rsp.hit            = o_hit;
  assign rsp.set_index      = o_set;
  assign rsp.way            = o_way;
  assign rsp.evicted        = o_ev;
  assign rsp.evicted_line   = o_evline;
  assign rsp.reuse_distance = o_reuse;

endmodule

// ===== rtl/sacl_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the cache LRU tracker, bound to its top level.
// Depends on sacl_pkg for field widths.
module sacl_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          rsp_hit,
  input logic                          rsp_evicted,
  input logic [sacl_pkg::LINE_W-1:0]   rsp_evicted_line,
  input logic [sacl_pkg::STAMP_W-1:0]  rsp_reuse_distance,
  input logic [sacl_pkg::TOTAL_W-1:0]  rsp_hit_total
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit_total))
    else $error("result word dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("address accepted while previous one still in progress");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_hit && rsp_evicted))
    else $error("hit reported with an eviction");

  a_clean_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_evicted || rsp_evicted_line == '0) &&
                  (rsp_hit || rsp_reuse_distance == '0))
    else $error("evicted line or reuse distance not zero when unused");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result word present after reset");

endmodule

bind set_assoc_cache_lru_tracker sacl_checker u_sacl_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_hit            (rsp.hit),
  .rsp_evicted        (rsp.evicted),
  .rsp_evicted_line   (rsp.evicted_line),
  .rsp_reuse_distance (rsp.reuse_distance),
  .rsp_hit_total      (rsp.hit_total)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for set_assoc_cache_lru_tracker: random and directed address words
// against an LRU cache predictor, over a series of register settings.
// Depends on rtl/sacl_pkg.sv, rtl/sacl_ifs.sv and rtl/set_assoc_cache_lru_tracker.sv.

typedef struct packed {
  logic                           hit;
  logic [sacl_pkg::SET_OUT_W-1:0] set_index;
  logic [sacl_pkg::WAY_OUT_W-1:0] way;
  logic                           evicted;
  logic [sacl_pkg::LINE_W-1:0]    evicted_line;
  logic [sacl_pkg::STAMP_W-1:0]   reuse_distance;
  logic [sacl_pkg::TOTAL_W-1:0]   hit_total;
  logic [sacl_pkg::TOTAL_W-1:0]   miss_total;
} cache_result_t;

class cache_scoreboard;
  logic [sacl_pkg::LINE_W-1:0]  line_mem   [sacl_pkg::SETS_DEF][sacl_pkg::WAYS_DEF];
  bit                           way_valid  [sacl_pkg::SETS_DEF][sacl_pkg::WAYS_DEF];
  bit [sacl_pkg::STAMP_W-1:0]   acc_stamp  [sacl_pkg::SETS_DEF][sacl_pkg::WAYS_DEF];
  bit [sacl_pkg::STAMP_W-1:0]   fill_stamp [sacl_pkg::SETS_DEF][sacl_pkg::WAYS_DEF];
  bit [sacl_pkg::STAMP_W-1:0]   acc_count  [sacl_pkg::SETS_DEF];
  bit [sacl_pkg::STAMP_W-1:0]   fill_count [sacl_pkg::SETS_DEF];
  bit [sacl_pkg::TOTAL_W-1:0]   hits;
  bit [sacl_pkg::TOTAL_W-1:0]   misses;
  bit [3:0]                     line_shift;
  bit [2:0]                     set_bits;
  bit [3:0]                     ways_used;
  cache_result_t                expected_results [$];
  int                           errors;
  int                           evictions;

  function new();
    for (int s = 0; s < sacl_pkg::SETS_DEF; s++) begin
      for (int w = 0; w < sacl_pkg::WAYS_DEF; w++) begin
        line_mem[s][w]   = '0;
        way_valid[s][w]  = 1'b0;
        acc_stamp[s][w]  = '0;
        fill_stamp[s][w] = '0;
      end
      acc_count[s]  = '0;
      fill_count[s] = '0;
    end
    hits       = '0;
    misses     = '0;
    line_shift = sacl_pkg::LINE_SHIFT_RST;
    set_bits   = sacl_pkg::SET_BITS_RST;
    ways_used  = sacl_pkg::WAYS_USED_RST;
    errors     = 0;
    evictions  = 0;
  endfunction

  function void write_reg(logic [sacl_pkg::CFG_IDX_W-1:0] idx,
                          logic [sacl_pkg::CFG_DATA_W-1:0] value);
    case (idx)
      sacl_pkg::CFG_LINE_SHIFT: line_shift = value;
      sacl_pkg::CFG_SET_BITS:   set_bits   = value[2:0];
      sacl_pkg::CFG_WAYS_USED:  ways_used  = value;
      default: ;
    endcase
  endfunction

  function int shift_used();
    return int'((line_shift > sacl_pkg::LINE_SHIFT_MAX) ? sacl_pkg::LINE_SHIFT_MAX
                                                        : line_shift);
  endfunction

  function int set_bits_used();
    return int'((set_bits > sacl_pkg::SET_BITS_MAX) ? sacl_pkg::SET_BITS_MAX : set_bits);
  endfunction

  function int ways_in_use();
    if (ways_used == 0) return 1;
    if (ways_used > sacl_pkg::WAYS_DEF) return sacl_pkg::WAYS_DEF;
    return int'(ways_used);
  endfunction

  function void note_access(logic [sacl_pkg::ADDR_W-1:0] address);
    int                          nw;
    int                          found;
    int                          empty;
    int                          victim;
    int                          sel;
    logic [sacl_pkg::LINE_W-1:0] line;
    cache_result_t               r;
    nw     = ways_in_use();
    found  = -1;
    empty  = -1;
    victim = 0;
    r      = '0;
    line   = address >> shift_used();
    sel    = int'(line & ((48'd1 << set_bits_used()) - 48'd1));
    for (int w = 0; w < nw; w++) begin
      if (way_valid[sel][w]) begin
        if (found < 0 && line_mem[sel][w] == line) found = w;
      end else if (empty < 0) begin
        empty = w;
      end
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      acc_stamp[sel][found] = acc_count[sel];
      acc_count[sel]++;
      r.reuse_distance = fill_count[sel] - fill_stamp[sel][found] - 32'd1;
      hits++;
      victim = found;
    end else begin
      misses++;
      if (empty >= 0) begin
        victim = empty;
      end else begin
        for (int w = 1; w < nw; w++)
          if (acc_stamp[sel][w] < acc_stamp[sel][victim]) victim = w;
        r.evicted      = 1'b1;
        r.evicted_line = line_mem[sel][victim];
        evictions++;
      end
      line_mem[sel][victim]   = line;
      way_valid[sel][victim]  = 1'b1;
      acc_stamp[sel][victim]  = acc_count[sel];
      fill_stamp[sel][victim] = fill_count[sel];
      acc_count[sel]++;
      fill_count[sel]++;
    end
    r.set_index  = sel[5:0];
    r.way        = victim[2:0];
    r.hit_total  = hits;
    r.miss_total = misses;
    expected_results.push_back(r);
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  function void check_result(cache_result_t got);
    cache_result_t want;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: result word with nothing outstanding, expected none, actual %h",
               $time, got);
      return;
    end
    want = expected_results.pop_front();
    compare_field("hit",            64'(want.hit),            64'(got.hit));
    compare_field("set_index",      64'(want.set_index),      64'(got.set_index));
    compare_field("way",            64'(want.way),            64'(got.way));
    compare_field("evicted",        64'(want.evicted),        64'(got.evicted));
    compare_field("evicted_line",   64'(want.evicted_line),   64'(got.evicted_line));
    compare_field("reuse_distance", 64'(want.reuse_distance), 64'(got.reuse_distance));
    compare_field("hit_total",      64'(want.hit_total),      64'(got.hit_total));
    compare_field("miss_total",     64'(want.miss_total),     64'(got.miss_total));
  endfunction
endclass

module testbench;
  localparam logic [sacl_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASES        = 12;
  localparam int PHASE_WORDS   = 136;

  logic                              clk;
  logic                              rst;
  logic                              cfg_we;
  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_data;

  sacl_in_if  req ();
  sacl_out_if rsp ();

  set_assoc_cache_lru_tracker DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  cache_scoreboard             board;
  bit                          steady;
  int                          words_sent;
  cache_result_t               seen;
  logic [sacl_pkg::ADDR_W-1:0] recent [$];
  logic [sacl_pkg::ADDR_W-1:0] hot_tags [12];
  int                          hot_sets [3];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      seen = {rsp.hit, rsp.set_index, rsp.way, rsp.evicted, rsp.evicted_line,
              rsp.reuse_distance, rsp.hit_total, rsp.miss_total};
      board.check_result(seen);
    end
    rsp.ready <= steady || ($urandom_range(0, 99) >= 25);
  end

  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stall = 0;
      else stall++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [sacl_pkg::ADDR_W-1:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[sacl_pkg::ADDR_W-1:0];
  endfunction

  function automatic logic [sacl_pkg::ADDR_W-1:0] pick_address();
    int                          roll;
    int                          sh;
    int                          sb;
    logic [sacl_pkg::ADDR_W-1:0] a;
    logic [sacl_pkg::ADDR_W-1:0] offset;
    logic [sacl_pkg::ADDR_W-1:0] line;
    sh     = board.shift_used();
    sb     = board.set_bits_used();
    offset = rand48() & ((48'd1 << sh) - 48'd1);
    roll   = $urandom_range(0, 99);
    if (roll < 35 && recent.size() != 0) begin
      a = ((recent[$urandom_range(0, recent.size() - 1)] >> sh) << sh) | offset;
    end else if (roll < 85) begin
      line = (hot_tags[$urandom_range(0, board.ways_in_use() + 2)] << sb)
           | 48'(hot_sets[$urandom_range(0, 2)] & ((1 << sb) - 1));
      a = (line << sh) | offset;
    end else begin
      a = rand48();
    end
    recent.push_back(a);
    if (recent.size() > 24) void'(recent.pop_front());
    return a;
  endfunction

  task automatic refresh_pools();
    foreach (hot_tags[i]) hot_tags[i] = rand48();
    foreach (hot_sets[i]) hot_sets[i] = $urandom_range(0, sacl_pkg::SETS_DEF - 1);
    recent.delete();
  endtask

  task automatic send_word(logic [sacl_pkg::ADDR_W-1:0] address);
    while (!steady && $urandom_range(0, 99) < 25) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.address <= address;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    board.note_access(address);
    words_sent++;
  endtask

  // hold the sender until every result is back, then let the block settle
  task automatic drain();
    req.valid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(logic [3:0] shift_val, logic [3:0] sets_val,
                              logic [3:0] ways_val);
    logic [sacl_pkg::CFG_IDX_W-1:0]  idx [4];
    logic [sacl_pkg::CFG_DATA_W-1:0] val [4];
    idx = '{sacl_pkg::CFG_LINE_SHIFT, sacl_pkg::CFG_SET_BITS, sacl_pkg::CFG_WAYS_USED, CFG_SPARE};
    val = '{shift_val, sets_val, ways_val, 4'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      board.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [3:0]                  shift_tab [PHASES];
    logic [3:0]                  sets_tab  [PHASES];
    logic [3:0]                  ways_tab  [PHASES];
    logic [sacl_pkg::ADDR_W-1:0] directed  [$];
    board       = new();
    steady      = 1'b0;
    words_sent  = 0;
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    req.valid   <= 1'b0;
    req.address <= '0;

    shift_tab = '{4'd6, 4'd0, 4'd12, 4'd15, 4'd0, 4'd13, 4'd4,
                  4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
    sets_tab  = '{4'd6, 4'd0, 4'd6,  4'd15, 4'd7, 4'd1,  4'd3,
                  4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
    ways_tab  = '{4'd8, 4'd1, 4'd8,  4'd15, 4'd0, 4'd2,  4'd9,
                  4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
    for (int p = 7; p < PHASES; p++) begin
      shift_tab[p] = 4'($urandom_range(0, 15));
      sets_tab[p]  = 4'($urandom_range(0, 15));
      ways_tab[p]  = 4'($urandom_range(0, 15));
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // extremes, same-line hits, then one set filled and pushed into replacement
    directed = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'h0, 48'h3F, 48'hFFFF_FFFF_FFC0};
    for (int t = 1; t <= 8; t++) directed.push_back(48'(((t << 6) | 5) << 6));
    directed.push_back(48'(((1 << 6) | 5) << 6));
    directed.push_back(48'(((9 << 6) | 5) << 6));
    directed.push_back(48'(((2 << 6) | 5) << 6));
    foreach (directed[i]) send_word(directed[i]);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) program_regs(shift_tab[p], sets_tab[p], ways_tab[p]);
      steady = (p == 2);
      refresh_pools();
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n == PHASE_WORDS / 2) drain();
        send_word(pick_address());
      end
      drain();
    end
    steady = 1'b0;

    $display("Covered %0d address words over %0d register settings", words_sent, PHASES);
    $display("Predicted %0d hits, %0d misses, %0d evictions",
             board.hits, board.misses, board.evictions);
    if (board.errors == 0 && board.expected_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
